[design/bpr_pkg.sv]
// Package for the broadcast purge ring: sizes, transaction types, status codes
// and the command/status structs between controller and datapath.
// No dependencies.
package bpr_pkg;

  localparam int RING_DEPTH    = 64;
  localparam int MAX_CONSUMERS = 16;

  localparam int PTR_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RP_DEPTH = (MAX_CONSUMERS < 16) ? MAX_CONSUMERS : 16;
  localparam int CID_W    = (RP_DEPTH > 1) ? $clog2(RP_DEPTH) : 1;
  localparam logic [4:0] CONS_LIM = 5'(RP_DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [5:0]       slot_t;
  typedef logic [4:0]       cnt_t;

  // result status codes
  localparam logic [2:0] ST_POSTED    = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DELIVERED = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_BADCONS   = 3'd4;

  // request types
  localparam logic REQ_POST  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // ring read address select
  localparam logic [1:0] RD_ACCEPT    = 2'd0;
  localparam logic [1:0] RD_NEXT_WP   = 2'd1;
  localparam logic [1:0] RD_WALK      = 2'd2;
  localparam logic [1:0] RD_WALK_NEXT = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  consumer_id;
    logic [63:0] range_start;
    logic [63:0] range_end;
    logic [5:0]  page_shift;
    logic [23:0] region_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    slot_t       slot_index;
    logic [63:0] out_start;
    logic [63:0] out_end;
    logic [5:0]  out_shift;
    logic [23:0] out_region;
    cnt_t        remaining;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] start_addr;
    logic [63:0] end_addr;
    logic [5:0]  shift;
    logic [23:0] region;
  } entry_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] rd_sel;
    logic       emit;
    logic [2:0] emit_kind;
    logic       post_write;
    logic       deliver;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic slot_busy;   // slot after the write pointer still pending
    logic bad_cons;
    logic walk_at_wp;
    logic walk_last;
    logic out_ready;
  } stat_t;

  function automatic ptr_t wrap_next(ptr_t p);
    return (p == ptr_t'(RING_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

[design/bpr_ctrl.sv]
// Controller state machine of the broadcast purge ring.
// Depends on bpr_pkg; drives the datapath through cmd_t and reads stat_t.
module bpr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_req_type,
  output logic           in_stall,
  output bpr_pkg::cmd_t  cmd,
  input  bpr_pkg::stat_t stat
);
  import bpr_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PCHK  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.rd_sel = RD_ACCEPT;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_req_type == REQ_DRAIN) ? S_DRAIN : S_PCHK;
        end
      end
      S_PCHK: begin
        // hold the read of the following slot's count until the result can go out
        cmd.rd_sel = RD_NEXT_WP;
        if (stat.out_ready) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = stat.slot_busy ? ST_FULL : ST_POSTED;
          cmd.post_write = !stat.slot_busy;
          state_nxt      = S_IDLE;
        end
      end
      S_DRAIN: begin
        cmd.rd_sel = RD_WALK;
        if (stat.out_ready) begin
          cmd.emit = 1'b1;
          if (stat.bad_cons) begin
            cmd.emit_kind = ST_BADCONS;
            state_nxt     = S_IDLE;
          end else if (stat.walk_at_wp) begin
            cmd.emit_kind = ST_EMPTY;
            state_nxt     = S_IDLE;
          end else begin
            // deliver one slot and advance the walk
            cmd.emit_kind = ST_DELIVERED;
            cmd.deliver   = 1'b1;
            cmd.rd_sel    = RD_WALK_NEXT;
            if (stat.walk_last) begin
              cmd.finish = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/bpr_dpath.sv]
// Datapath of the broadcast purge ring: entry and count memories, pointers,
// configuration register and the output register. Depends on bpr_pkg.
module bpr_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  bpr_pkg::in_item_t   in_data,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata,
  input  bpr_pkg::cmd_t       cmd,
  output bpr_pkg::stat_t      stat,
  output logic                out_valid,
  input  logic                out_stall,
  output bpr_pkg::out_item_t  out_data
);
  import bpr_pkg::*;

  entry_t   ent_mem [RING_DEPTH];
  cnt_t     pend_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] pend_vld_r;

  entry_t   ent_rd_r;
  cnt_t     pend_rd_r;
  logic     pend_rd_vld_r;

  ptr_t     wp_r, walk_r;
  ptr_t     rp_r [RP_DEPTH];
  in_item_t inp_r;
  cnt_t     cfg_r;

  logic      out_valid_r;
  out_item_t out_data_r, out_nxt;

  ptr_t     wp_next, walk_next, in_rp, rd_addr;
  cnt_t     eff, pend_cnt, pend_dec;
  logic [CID_W-1:0] in_idx, cur_idx;

  assign wp_next   = wrap_next(wp_r);
  assign walk_next = wrap_next(walk_r);
  assign in_idx    = in_data.consumer_id[CID_W-1:0];
  assign cur_idx   = inp_r.consumer_id[CID_W-1:0];
  assign in_rp     = ({1'b0, in_data.consumer_id} < 5'(RP_DEPTH)) ? rp_r[in_idx] : '0;

  // clamp the consumer count to 1..limit
  always_comb begin
    eff = cfg_r;
    if (eff == 5'd0) begin
      eff = 5'd1;
    end
    if (eff > CONS_LIM) begin
      eff = CONS_LIM;
    end
  end

  assign pend_cnt = pend_rd_vld_r ? pend_rd_r : '0;
  assign pend_dec = (pend_cnt != 5'd0) ? pend_cnt - 5'd1 : 5'd0;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_ACCEPT:    rd_addr = (in_data.req_type == REQ_DRAIN) ? in_rp : wp_next;
      RD_NEXT_WP:   rd_addr = wp_next;
      RD_WALK:      rd_addr = walk_r;
      RD_WALK_NEXT: rd_addr = walk_next;
    endcase
  end

  assign stat.slot_busy  = (pend_cnt != 5'd0);
  assign stat.bad_cons   = ({1'b0, inp_r.consumer_id} >= eff);
  assign stat.walk_at_wp = (walk_r == wp_r);
  assign stat.walk_last  = (walk_next == wp_r);
  assign stat.out_ready  = !out_valid_r || !out_stall;

  // ring memories: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.post_write) begin
      ent_mem[wp_r] <= '{start_addr: inp_r.range_start, end_addr: inp_r.range_end,
                         shift: inp_r.page_shift, region: inp_r.region_id};
    end
    if (cmd.post_write) begin
      pend_mem[wp_r] <= eff;
    end else if (cmd.deliver) begin
      pend_mem[walk_r] <= pend_dec;
    end
    ent_rd_r  <= ent_mem[rd_addr];
    pend_rd_r <= pend_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r    <= '0;
      pend_rd_vld_r <= 1'b0;
    end else begin
      pend_rd_vld_r <= pend_vld_r[rd_addr];
      if (cmd.post_write) begin
        pend_vld_r[wp_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      cfg_r <= 5'd1;
      for (int i = 0; i < RP_DEPTH; i++) begin
        rp_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (cmd.post_write) begin
        wp_r <= wp_next;
      end
      if (cmd.finish) begin
        rp_r[cur_idx] <= walk_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      inp_r  <= in_data;
      walk_r <= in_rp;
    end else if (cmd.deliver) begin
      walk_r <= walk_next;
    end
  end

  always_comb begin
    out_nxt        = '0;
    out_nxt.status = cmd.emit_kind;
    out_nxt.last   = 1'b1;
    unique case (cmd.emit_kind)
      ST_POSTED: begin
        out_nxt.slot_index = slot_t'(wp_r);
        out_nxt.out_start  = inp_r.range_start;
        out_nxt.out_end    = inp_r.range_end;
        out_nxt.out_shift  = inp_r.page_shift;
        out_nxt.out_region = inp_r.region_id;
        out_nxt.remaining  = eff;
      end
      ST_FULL: begin
        out_nxt.slot_index = slot_t'(wp_r);
      end
      ST_DELIVERED: begin
        out_nxt.slot_index = slot_t'(walk_r);
        out_nxt.out_start  = ent_rd_r.start_addr;
        out_nxt.out_end    = ent_rd_r.end_addr;
        out_nxt.out_shift  = ent_rd_r.shift;
        out_nxt.out_region = ent_rd_r.region;
        out_nxt.remaining  = pend_dec;
        out_nxt.last       = stat.walk_last;
      end
      ST_EMPTY: begin
        out_nxt.slot_index = slot_t'(walk_r);
      end
      default: begin
        out_nxt.slot_index = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/broadcast_purge_ring.sv]
// Top level of the broadcast purge ring: controller plus datapath.
// Depends on bpr_pkg, bpr_ctrl and bpr_dpath.
//
//   channel   handshake            payload
//   in        in_valid / in_stall  in_data   (bpr_pkg::in_item_t)
//   out       out_valid/ out_stall out_data  (bpr_pkg::out_item_t)
//   cfg       cfg_we               cfg_wdata (consumer count, 5 bits)
//
// A post is accepted with a registered read of the following slot's pending count,
// then the result is emitted and the input is free again. A drain delivers its
// entries slot by slot behind the registered ring read; bad consumer and empty
// requests give a single result. Reset (synchronous, rst_n low) clears all
// pending counts at once through per-slot valid bits. An output stall holds the
// walk in place; the input stays stalled until the last result is loaded.
module broadcast_purge_ring (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bpr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bpr_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata
);
  import bpr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bpr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .stat        (stat)
  );

  bpr_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[design/bpr_checker.sv]
// Port-level checks for the broadcast purge ring, bound to the top level.
// Depends on bpr_pkg and broadcast_purge_ring.
module bpr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input bpr_pkg::out_item_t out_data,
  input logic               out_valid,
  input logic               out_stall
);
  import bpr_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one request at a time: busy right after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a request is in flight");

  // every result other than a delivery is the only one of its request
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_DELIVERED |-> out_data.last)
    else $error("non-delivery result without last");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_BADCONS
      |-> out_data.slot_index == '0 && out_data.remaining == '0)
    else $error("bad consumer result carries data");

endmodule

bind broadcast_purge_ring bpr_checker u_bpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
